// File: rtl/pfra_pkg.sv
`timescale 1ns / 1ps

package pfra_pkg;

	localparam int PAGES      = 4096;
	localparam int IDX_W      = $clog2(PAGES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int PAGE_SHIFT = 12;

	localparam logic [31:0] LOW_BASE    = 32'h0010_0000;
	localparam logic [7:0]  USED_MARK   = 8'd100;
	localparam logic [7:0]  COUNT_MAX   = 8'hFF;
	localparam logic [31:0] FRAME_MASK  = 32'hFFFF_F000;
	localparam logic [31:0] WRITE_CLEAR = ~32'd2;
	localparam logic [31:0] COW_FLAGS   = 32'd7;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_ERR    = 2'd2;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_SHARE = 2'd2,
		CMD_COW   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_REF,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [31:0] word;
	} rsp_t;

endpackage

// File: rtl/page_frame_refcount_allocator.sv
`timescale 1ns / 1ps

// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | cmd, address_word, end_address
// output  | out_valid| out_stall | status, result_word
//
// Counts live in one 4096 x 8 RAM, one entry read and one entry written per cycle.
// share: count read, then updated; alloc: scan upward from the lowest-free hint (finds nothing when the hint
// marks the table full); cow: release, then the same scan as alloc; init: full RAM rewrite.
// After reset a clearing pass zeroes the RAM; in_stall is high meanwhile.
// A finished result sits in the output register, so the next beat is taken while it waits.

module page_frame_refcount_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] address_word,
	input  logic [31:0] end_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_word
);

	pfra_pkg::mem_req_t mem_req;
	pfra_pkg::rsp_t     rsp;
	logic [7:0]         mem_rdata;
	logic               out_free;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [31:0]        result_q;

	assign out_free = !out_valid_q || !out_stall;

	pfra_ram #(
		.WIDTH (8),
		.DEPTH (pfra_pkg::PAGES)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	pfra_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.address_word (address_word),
		.end_address  (end_address),
		.out_free     (out_free),
		.rsp          (rsp),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.valid) begin
			status_q <= rsp.status;
			result_q <= rsp.word;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_word = result_q;

	a_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken beat");

	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> in_stall)
		else $error("count RAM written while taking a beat");

	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !rsp.valid)
		else $error("result in the cycle after accept");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status != 2'd3))
		else $error("undefined status code");

endmodule

// File: rtl/pfra_ram.sv
`timescale 1ns / 1ps

module pfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pfra_ctrl.sv
`timescale 1ns / 1ps

module pfra_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic [31:0]          address_word,
	input  logic [31:0]          end_address,
	input  logic                 out_free,
	output pfra_pkg::rsp_t       rsp,
	output pfra_pkg::mem_req_t   mem_req,
	input  logic [7:0]           mem_rdata
);

	pfra_pkg::state_t state_q, state_nxt;

	pfra_pkg::cmd_t                   cmd_q;
	logic [pfra_pkg::CNT_W-1:0]       ptr_q;
	logic [pfra_pkg::CNT_W-1:0]       hint_q;
	logic                             pend_s1;
	logic [pfra_pkg::IDX_W-1:0]       addr_s1;
	logic [pfra_pkg::IDX_W-1:0]       idx_q;
	logic                             touch_q;
	logic                             err_q;
	logic                             nofree_q;
	logic [31:0]                      res_word_q;
	logic signed [20:0]               first_q;
	logic [19:0]                      n_q;

	// input decode
	pfra_pkg::cmd_t       in_cmd;
	logic                 accept;
	logic [31:0]          ent_clr;
	logic [31:0]          ent_old;
	logic [31:0]          ent_src;
	logic                 ent_hit;
	logic [31:0]          ent_diff;
	logic [19:0]          ent_idx;
	logic                 ent_in_tab;
	logic signed [32:0]   init_d;
	logic [31:0]          init_span;
	logic [19:0]          init_n;

	// init sweep
	logic signed [21:0]   k_s;
	logic signed [21:0]   first_x;
	logic signed [21:0]   hi_full;
	logic                 in_rng;
	logic                 init_err;
	logic                 init_free;
	logic [pfra_pkg::CNT_W-1:0] lo_c;

	// ref update / scan
	logic                 ptr_last;
	logic                 ref_ok;
	logic                 ref_zero;
	logic [pfra_pkg::CNT_W-1:0] ref_hint;
	logic                 found;
	logic                 scan_none;
	logic [31:0]          found_addr;

	function automatic logic [pfra_pkg::CNT_W-1:0] CNT_W_cast(input logic signed [20:0] v);
		logic [pfra_pkg::CNT_W-1:0] r;
		if (22'(v) >= $signed(22'(pfra_pkg::PAGES))) begin
			r = pfra_pkg::CNT_W'(pfra_pkg::PAGES);
		end else begin
			r = v[pfra_pkg::CNT_W-1:0];
		end
		return r;
	endfunction

	assign in_cmd = pfra_pkg::cmd_t'(cmd);
	assign accept = in_valid && (state_q == pfra_pkg::S_IDLE);

	assign ent_clr    = address_word & pfra_pkg::WRITE_CLEAR;
	assign ent_old    = address_word & pfra_pkg::FRAME_MASK;
	assign ent_src    = (in_cmd == pfra_pkg::CMD_SHARE) ? ent_clr : ent_old;
	assign ent_hit    = (in_cmd == pfra_pkg::CMD_SHARE) ? (ent_clr > pfra_pkg::LOW_BASE)
	                                                    : (ent_old >= pfra_pkg::LOW_BASE);
	assign ent_diff   = ent_src - pfra_pkg::LOW_BASE;
	assign ent_idx    = ent_diff[31:pfra_pkg::PAGE_SHIFT];
	assign ent_in_tab = 32'(ent_idx) < 32'(pfra_pkg::PAGES);

	// floor((word - base) / 4096) is an arithmetic shift of the 33-bit difference
	assign init_d    = $signed({1'b0, address_word}) - $signed({1'b0, pfra_pkg::LOW_BASE});
	assign init_span = end_address - address_word;
	assign init_n    = (end_address > address_word) ? init_span[31:pfra_pkg::PAGE_SHIFT] : 20'd0;

	assign k_s       = $signed(22'(ptr_q));
	assign first_x   = 22'(first_q);
	assign hi_full   = first_x + $signed({2'b00, n_q});
	assign in_rng    = (n_q != 20'd0) && (k_s >= first_x) && (k_s < hi_full);
	assign init_err  = (n_q != 20'd0) &&
	                   ((first_q < 0) || (hi_full > $signed(22'(pfra_pkg::PAGES))));
	assign init_free = (n_q != 20'd0) && (hi_full > 0) &&
	                   (first_x < $signed(22'(pfra_pkg::PAGES)));
	assign lo_c      = (first_q < 0) ? '0 : CNT_W_cast(first_q);

	assign ptr_last = ptr_q == pfra_pkg::CNT_W'(pfra_pkg::PAGES - 1);

	assign ref_ok   = touch_q && ((cmd_q == pfra_pkg::CMD_SHARE) ? (mem_rdata != pfra_pkg::COUNT_MAX)
	                                                             : (mem_rdata != 8'd0));
	// a cow release that reaches zero may open a free page below the hint
	assign ref_zero = touch_q && (cmd_q == pfra_pkg::CMD_COW) && (mem_rdata == 8'd1);
	assign ref_hint = (ref_zero && (pfra_pkg::CNT_W'(idx_q) < hint_q)) ? pfra_pkg::CNT_W'(idx_q)
	                                                                  : hint_q;

	assign found      = pend_s1 && (mem_rdata == 8'd0);
	assign scan_none  = !pend_s1 && (ptr_q == pfra_pkg::CNT_W'(pfra_pkg::PAGES));
	assign found_addr = pfra_pkg::LOW_BASE + (32'(addr_s1) << pfra_pkg::PAGE_SHIFT);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pfra_pkg::S_CLEAR: begin
				if (ptr_last) state_nxt = pfra_pkg::S_IDLE;
			end
			pfra_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd)
						pfra_pkg::CMD_INIT:  state_nxt = pfra_pkg::S_INIT;
						pfra_pkg::CMD_ALLOC: state_nxt = pfra_pkg::S_SCAN;
						pfra_pkg::CMD_SHARE,
						pfra_pkg::CMD_COW:   state_nxt = pfra_pkg::S_REF;
					endcase
				end
			end
			pfra_pkg::S_INIT: begin
				if (ptr_last) state_nxt = pfra_pkg::S_RESP;
			end
			pfra_pkg::S_REF: begin
				state_nxt = (cmd_q == pfra_pkg::CMD_COW) ? pfra_pkg::S_SCAN : pfra_pkg::S_RESP;
			end
			pfra_pkg::S_SCAN: begin
				if (found || scan_none) state_nxt = pfra_pkg::S_RESP;
			end
			pfra_pkg::S_RESP: begin
				if (out_free) state_nxt = pfra_pkg::S_IDLE;
			end
			default: state_nxt = pfra_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = (state_q != pfra_pkg::S_IDLE);
		mem_req.we    = 1'b0;
		mem_req.waddr = ptr_q[pfra_pkg::IDX_W-1:0];
		mem_req.wdata = 8'd0;
		mem_req.raddr = ptr_q[pfra_pkg::IDX_W-1:0];
		rsp.valid     = 1'b0;
		rsp.status    = nofree_q ? pfra_pkg::ST_NOFREE :
		                err_q    ? pfra_pkg::ST_ERR    : pfra_pkg::ST_OK;
		rsp.word      = res_word_q;
		unique case (state_q)
			pfra_pkg::S_CLEAR: begin
				mem_req.we = 1'b1;
			end
			pfra_pkg::S_IDLE: begin
				mem_req.raddr = ent_idx[pfra_pkg::IDX_W-1:0];
			end
			pfra_pkg::S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = in_rng ? 8'd0 : pfra_pkg::USED_MARK;
			end
			pfra_pkg::S_REF: begin
				mem_req.we    = ref_ok;
				mem_req.waddr = idx_q;
				mem_req.wdata = (cmd_q == pfra_pkg::CMD_SHARE) ? mem_rdata + 8'd1 : mem_rdata - 8'd1;
			end
			pfra_pkg::S_SCAN: begin
				mem_req.we    = found;
				mem_req.waddr = addr_s1;
				mem_req.wdata = 8'd1;
			end
			pfra_pkg::S_RESP: begin
				rsp.valid = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfra_pkg::S_CLEAR;
			ptr_q   <= '0;
			hint_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				pfra_pkg::S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) hint_q <= '0;
				end
				pfra_pkg::S_IDLE: begin
					pend_s1 <= 1'b0;
					ptr_q   <= (in_cmd == pfra_pkg::CMD_INIT) ? '0 : hint_q;
				end
				pfra_pkg::S_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) hint_q <= init_free ? lo_c : pfra_pkg::CNT_W'(pfra_pkg::PAGES);
				end
				pfra_pkg::S_REF: begin
					hint_q <= ref_hint;
					ptr_q  <= ref_hint;
				end
				pfra_pkg::S_SCAN: begin
					if (found) begin
						hint_q <= pfra_pkg::CNT_W'(addr_s1) + 1'b1;
					end else if (ptr_q != pfra_pkg::CNT_W'(pfra_pkg::PAGES)) begin
						pend_s1 <= 1'b1;
						ptr_q   <= ptr_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				pfra_pkg::S_RESP: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_cmd;
			idx_q      <= ent_idx[pfra_pkg::IDX_W-1:0];
			touch_q    <= ent_hit && ent_in_tab;
			err_q      <= (in_cmd == pfra_pkg::CMD_SHARE || in_cmd == pfra_pkg::CMD_COW) &&
			              ent_hit && !ent_in_tab;
			nofree_q   <= 1'b0;
			res_word_q <= (in_cmd == pfra_pkg::CMD_SHARE) ? ent_clr : 32'd0;
			first_q    <= $signed(init_d[32:pfra_pkg::PAGE_SHIFT]);
			n_q        <= init_n;
		end
		if (state_q == pfra_pkg::S_INIT && ptr_last) begin
			err_q <= init_err;
		end
		if (state_q == pfra_pkg::S_REF && touch_q && !ref_ok) begin
			err_q <= 1'b1;
		end
		if (state_q == pfra_pkg::S_SCAN) begin
			addr_s1 <= ptr_q[pfra_pkg::IDX_W-1:0];
			if (found) begin
				res_word_q <= (cmd_q == pfra_pkg::CMD_COW) ? (found_addr | pfra_pkg::COW_FLAGS)
				                                           : found_addr;
			end else if (scan_none) begin
				nofree_q   <= 1'b1;
				res_word_q <= 32'd0;
			end
		end
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int RANDOM_BEATS = 1980;
	localparam int QUIET_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 400;
	localparam int FULL_BUDGET  = 60;

	typedef struct {
		pfra_pkg::cmd_t op;
		logic [31:0]    word;
		logic [31:0]    end_addr;
	} beat_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] word;
	} result_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd          = pfra_pkg::CMD_INIT;
	logic [31:0] address_word = '0;
	logic [31:0] end_address  = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_word;

	page_frame_refcount_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.address_word (address_word),
		.end_address  (end_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_word  (result_word)
	);

	// predicted page counts
	logic [7:0] frame_refs [pfra_pkg::PAGES];

	beat_t   cmd_q [$];
	result_t want_q [$];
	beat_t   nxt;
	result_t got_want;

	bit in_took   = 1'b0;
	bit out_took  = 1'b0;
	bit src_calm  = 1'b0;
	bit snk_calm  = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int src_gap   = 0;
	int snk_gap   = 0;
	int hold_left = 0;
	int quiet     = 0;
	int n_bad     = 0;
	int n_checked = 0;
	int n_made    = 0;
	int full_hits = 0;
	int win_lo    = 0;
	int win_n     = 1;
	int cmd_seen [4];
	int stat_seen [3];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < pfra_pkg::PAGES; i++)
			frame_refs[i] = 8'd0;
		for (int i = 0; i < 4; i++)
			cmd_seen[i] = 0;
		for (int i = 0; i < 3; i++)
			stat_seen[i] = 0;
	end

	function automatic logic [31:0] frame_addr(input int idx);
		return pfra_pkg::LOW_BASE + (32'(idx) << pfra_pkg::PAGE_SHIFT);
	endfunction

	// first zero count wins, like the hardware scan
	function automatic int claim_frame();
		for (int i = 0; i < pfra_pkg::PAGES; i++)
			if (frame_refs[i] == 8'd0) begin
				frame_refs[i] = 8'd1;
				return i;
			end
		return -1;
	endfunction

	task automatic apply_command(input beat_t b, output result_t r);
		longint      offs, first, span, lo, hi;
		logic [31:0] e;
		int          idx, got;
		r.status = pfra_pkg::ST_OK;
		r.word   = '0;
		case (b.op)
			pfra_pkg::CMD_INIT: begin
				for (int k = 0; k < pfra_pkg::PAGES; k++)
					frame_refs[k] = pfra_pkg::USED_MARK;
				offs  = longint'({32'd0, b.word}) - longint'({32'd0, pfra_pkg::LOW_BASE});
				first = offs >>> pfra_pkg::PAGE_SHIFT;
				span  = (b.end_addr > b.word) ?
				        ((b.end_addr - b.word) >> pfra_pkg::PAGE_SHIFT) : 0;
				if (span > 0) begin
					if (first < 0 || first + span > pfra_pkg::PAGES)
						r.status = pfra_pkg::ST_ERR;
					lo = (first < 0) ? 0 : first;
					hi = (first + span > pfra_pkg::PAGES) ? pfra_pkg::PAGES : first + span;
					for (longint k = lo; k < hi; k++)
						frame_refs[k] = 8'd0;
				end
			end
			pfra_pkg::CMD_ALLOC: begin
				got = claim_frame();
				if (got >= 0)
					r.word = frame_addr(got);
				else
					r.status = pfra_pkg::ST_NOFREE;
			end
			pfra_pkg::CMD_SHARE: begin
				e = b.word & pfra_pkg::WRITE_CLEAR;
				r.word = e;
				if (e > pfra_pkg::LOW_BASE) begin
					idx = (e - pfra_pkg::LOW_BASE) >> pfra_pkg::PAGE_SHIFT;
					if (idx >= pfra_pkg::PAGES || frame_refs[idx] == pfra_pkg::COUNT_MAX)
						r.status = pfra_pkg::ST_ERR;
					else
						frame_refs[idx] = frame_refs[idx] + 8'd1;
				end
			end
			default: begin
				e = b.word & pfra_pkg::FRAME_MASK;
				if (e >= pfra_pkg::LOW_BASE) begin
					idx = (e - pfra_pkg::LOW_BASE) >> pfra_pkg::PAGE_SHIFT;
					if (idx >= pfra_pkg::PAGES || frame_refs[idx] == 8'd0)
						r.status = pfra_pkg::ST_ERR;
					else
						frame_refs[idx] = frame_refs[idx] - 8'd1;
				end
				// release happens even when the claim fails
				got = claim_frame();
				if (got >= 0) begin
					r.word = frame_addr(got) | pfra_pkg::COW_FLAGS;
				end else begin
					r.status = pfra_pkg::ST_NOFREE;
					r.word   = '0;
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		n_bad++;
		if (n_bad <= 10)
			$display("mismatch on result %0d, %s: expected %h, got %h",
				n_checked, field, want, got);
	endtask

	// input driver: one beat in flight, random gap drawn per beat
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				nxt = cmd_q.pop_front();
				cmd          <= nxt.op;
				address_word <= nxt.word;
				end_address  <= nxt.end_addr;
				in_valid     <= 1'b1;
				src_gap = src_calm ? 0 : $urandom_range(0, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stall, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (out_took)
			snk_gap = snk_calm ? 0 : $urandom_range(0, 13);
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (out_valid && snk_gap > 0) begin
			snk_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on input beats, check output beats, watch for hangs
	always @(posedge clk) begin
		result_t r;
		beat_t   b;
		in_took  <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall) begin
			b.op       = pfra_pkg::cmd_t'(cmd);
			b.word     = address_word;
			b.end_addr = end_address;
			apply_command(b, r);
			want_q.push_back(r);
			cmd_seen[b.op]++;
			stat_seen[r.status]++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (want_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("result with nothing pending: status %0d word %h",
						status, result_word);
			end else begin
				got_want = want_q.pop_front();
				if (status !== got_want.status)
					note_mismatch("status", got_want.status, status);
				if (result_word !== got_want.word)
					note_mismatch("result_word", got_want.word, result_word);
			end
			n_checked++;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic queue_beat(input pfra_pkg::cmd_t op, input logic [31:0] w,
			input logic [31:0] e);
		beat_t b;
		b.op       = op;
		b.word     = w;
		b.end_addr = e;
		while (cmd_q.size() >= 4)
			@(posedge clk);
		cmd_q.push_back(b);
	endtask

	// mostly entries in the current free window, some at the edges and wild
	function automatic logic [31:0] pick_entry();
		logic [31:0] e;
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: e = $urandom_range(0, pfra_pkg::LOW_BASE);
			2: e = frame_addr(pfra_pkg::PAGES - 1 - $urandom_range(0, 3));
			3: e = frame_addr(pfra_pkg::PAGES + $urandom_range(0, 3));
			default: e = frame_addr(win_lo + $urandom_range(0, win_n + 2));
		endcase
		return (e & pfra_pkg::FRAME_MASK) | 32'($urandom_range(0, 4095));
	endfunction

	initial begin
		int          roll, avail, sat_idx;
		logic [31:0] w;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: edge entries and every corner of the four commands
		queue_beat(pfra_pkg::CMD_ALLOC, '0, '1);
		queue_beat(pfra_pkg::CMD_SHARE, pfra_pkg::LOW_BASE | 32'h3, '0);
		queue_beat(pfra_pkg::CMD_SHARE, pfra_pkg::LOW_BASE | 32'h2, '0);
		queue_beat(pfra_pkg::CMD_SHARE, '0, '0);
		queue_beat(pfra_pkg::CMD_SHARE, '1, '1);
		queue_beat(pfra_pkg::CMD_SHARE, 32'h000F_F002, '0);
		queue_beat(pfra_pkg::CMD_COW, frame_addr(1) | 32'h1, '0);
		queue_beat(pfra_pkg::CMD_COW, frame_addr(0), '0);
		queue_beat(pfra_pkg::CMD_COW, 32'h0000_5007, '0);
		queue_beat(pfra_pkg::CMD_COW, 32'hFFFF_F001, '0);
		queue_beat(pfra_pkg::CMD_INIT, pfra_pkg::LOW_BASE, frame_addr(2));
		queue_beat(pfra_pkg::CMD_ALLOC, '0, '0);
		queue_beat(pfra_pkg::CMD_ALLOC, '0, '0);
		queue_beat(pfra_pkg::CMD_ALLOC, '0, '0);
		queue_beat(pfra_pkg::CMD_COW, frame_addr(0) | 32'h1, '0);
		queue_beat(pfra_pkg::CMD_COW, 32'h0000_3001, '0);
		queue_beat(pfra_pkg::CMD_COW, 32'hFFFF_F003, '0);
		queue_beat(pfra_pkg::CMD_INIT, frame_addr(5), frame_addr(0));
		queue_beat(pfra_pkg::CMD_INIT, pfra_pkg::LOW_BASE - 32'h3800,
			pfra_pkg::LOW_BASE + 32'h2000);
		queue_beat(pfra_pkg::CMD_INIT, frame_addr(pfra_pkg::PAGES - 2),
			frame_addr(pfra_pkg::PAGES + 3));
		queue_beat(pfra_pkg::CMD_INIT, '0, '1);
		queue_beat(pfra_pkg::CMD_INIT, '1, '0);
		queue_beat(pfra_pkg::CMD_ALLOC, '0, '0);
		queue_beat(pfra_pkg::CMD_SHARE, frame_addr(pfra_pkg::PAGES - 1) | 32'h2, '0);
		queue_beat(pfra_pkg::CMD_INIT, frame_addr(16) + 32'h123, frame_addr(28) + 32'h456);
		win_lo = 16;
		win_n  = 12;

		while (n_made < RANDOM_BEATS) begin
			if (n_made % 150 == 0) begin
				src_calm = ($urandom_range(0, 3) == 0);
				snk_calm = ($urandom_range(0, 3) == 0);
			end
			if (n_made >= 900)
				hold_req = 1'b1;
			if (n_made == 500 || n_made == 1500) begin
				// hammer one page until its count pins at the top
				sat_idx = win_lo + $urandom_range(0, win_n - 1);
				for (int k = 0; k < 258; k++)
					queue_beat(pfra_pkg::CMD_SHARE,
						frame_addr(sat_idx) | 32'($urandom_range(0, 4095)), $urandom);
				n_made += 258;
				continue;
			end
			avail = 0;
			for (int i = 0; i < pfra_pkg::PAGES; i++)
				if (frame_refs[i] == 8'd0)
					avail++;
			roll = $urandom_range(0, 99);
			// a full table can make each claim walk up to the last page; keep that bounded
			if (roll < 3 || (avail == 0 && full_hits >= FULL_BUDGET)) begin
				if ($urandom_range(0, 4) == 0) begin
					queue_beat(pfra_pkg::CMD_INIT, $urandom, $urandom);
				end else begin
					win_lo = $urandom_range(0, 48);
					win_n  = $urandom_range(1, 20);
					w = frame_addr(win_lo) + 32'($urandom_range(0, 4095));
					queue_beat(pfra_pkg::CMD_INIT, w,
						w + (32'(win_n) << pfra_pkg::PAGE_SHIFT) +
						32'($urandom_range(0, 4095)));
				end
			end else if (roll < 35) begin
				if (avail == 0)
					full_hits++;
				queue_beat(pfra_pkg::CMD_ALLOC, $urandom, $urandom);
			end else if (roll < 62) begin
				queue_beat(pfra_pkg::CMD_SHARE, pick_entry(), $urandom);
			end else if (roll < 88) begin
				if (avail == 0)
					full_hits++;
				queue_beat(pfra_pkg::CMD_COW, pick_entry(), $urandom);
			end else begin
				if (avail == 0)
					full_hits++;
				queue_beat(pfra_pkg::cmd_t'($urandom_range(1, 3)), $urandom, $urandom);
			end
			n_made++;
		end

		while (cmd_q.size() != 0 || in_valid)
			@(posedge clk);
		while (want_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d commands: init %0d, alloc %0d, share %0d, cow %0d",
			cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
			cmd_seen[pfra_pkg::CMD_INIT], cmd_seen[pfra_pkg::CMD_ALLOC],
			cmd_seen[pfra_pkg::CMD_SHARE], cmd_seen[pfra_pkg::CMD_COW]);
		$display("%0d results checked (ok %0d, no free page %0d, error %0d), %0d mismatches",
			n_checked, stat_seen[pfra_pkg::ST_OK], stat_seen[pfra_pkg::ST_NOFREE],
			stat_seen[pfra_pkg::ST_ERR], n_bad);
		if (n_bad == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
